@@ sv/dssm_pkg.sv @@
package dssm_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W = 32;

	localparam logic [1:0] OP_PUSH_A = 2'd0;
	localparam logic [1:0] OP_PUSH_B = 2'd1;
	localparam logic [1:0] OP_POP_A = 2'd2;
	localparam logic [1:0] OP_POP_B = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic load;
		logic push;
		logic pop;
		logic emit;
		logic use_data;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic full;
		logic empty_a;
		logic empty_b;
	} stat_t;

endpackage

@@ sv/dssm_ram.sv @@
module dssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ sv/dssm_ctrl.sv @@
module dssm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input dssm_pkg::stat_t stat,
	output dssm_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic is_pop;
	logic is_b;
	logic empty;

	assign is_pop = (stat.op == dssm_pkg::OP_POP_A) || (stat.op == dssm_pkg::OP_POP_B);
	assign is_b = (stat.op == dssm_pkg::OP_PUSH_B) || (stat.op == dssm_pkg::OP_POP_B);
	assign empty = is_b ? stat.empty_b : stat.empty_a;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.code = dssm_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (is_pop) begin
					if (empty) begin
						cmd.emit = 1'b1;
						cmd.code = dssm_pkg::ST_UNDERFLOW;
						state_d = S_IDLE;
					end else begin
						cmd.pop = 1'b1;
						state_d = S_READ;
					end
				end else begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
					if (stat.full) begin
						cmd.code = dssm_pkg::ST_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.emit = 1'b1;
				cmd.use_data = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/dssm_datapath.sv @@
module dssm_datapath #(
	parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input dssm_pkg::cmd_t cmd,
	output dssm_pkg::stat_t stat,
	input logic [1:0] operation,
	input logic signed [31:0] push_value,
	output logic done,
	output logic signed [31:0] pop_value,
	output logic [1:0] status
);

	localparam int HW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [1:0] op_q;
	logic [dssm_pkg::DATA_W-1:0] value_q;
	logic [HW-1:0] height_a_q;
	logic [HW-1:0] height_b_q;
	logic done_q;
	logic [dssm_pkg::DATA_W-1:0] pop_value_q;
	logic [1:0] status_q;
	logic [HW:0] height_sum;
	logic is_b;
	logic [HW-1:0] addr_full;
	logic [dssm_pkg::DATA_W-1:0] rdata;

	assign height_sum = {1'b0, height_a_q} + {1'b0, height_b_q};
	assign is_b = (op_q == dssm_pkg::OP_PUSH_B) || (op_q == dssm_pkg::OP_POP_B);

	assign stat.op = op_q;
	assign stat.full = (height_sum >= (HW + 1)'(DEPTH));
	assign stat.empty_a = (height_a_q == '0);
	assign stat.empty_b = (height_b_q == '0);

	always_comb begin
		if (is_b) begin
			addr_full = cmd.pop ? (HW'(DEPTH) - height_b_q) : (HW'(DEPTH - 1) - height_b_q);
		end else begin
			addr_full = cmd.pop ? (height_a_q - HW'(1)) : height_a_q;
		end
	end

	dssm_ram #(
		.WIDTH(dssm_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(cmd.push),
		.addr(addr_full[AW-1:0]),
		.wdata(value_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			value_q <= push_value;
		end
		if (cmd.emit) begin
			pop_value_q <= cmd.use_data ? rdata : '0;
			status_q <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_a_q <= '0;
			height_b_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.push) begin
				if (is_b) begin
					height_b_q <= height_b_q + HW'(1);
				end else begin
					height_a_q <= height_a_q + HW'(1);
				end
			end else if (cmd.pop) begin
				if (is_b) begin
					height_b_q <= height_b_q - HW'(1);
				end else begin
					height_a_q <= height_a_q - HW'(1);
				end
			end
		end
	end

	assign done = done_q;
	assign pop_value = pop_value_q;
	assign status = status_q;

	a_heights_fit: assert property (@(posedge clk) disable iff (!arst_n)
		height_sum <= (HW + 1)'(DEPTH))
		else $error("stack heights exceed the store depth");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != dssm_pkg::ST_OK) |-> (pop_value_q == '0))
		else $error("refused operation returned a nonzero word");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push issued into a full store");

endmodule

@@ sv/dual_stack_shared_memory_top.sv @@
// A push or a refused operation is loaded when start is taken and its result is registered in the execute state.
// A successful pop issues the RAM read in the execute state and registers the read word in the read state.
// busy drops in the cycle the result strobe rises, so no new operation is taken before the last result shows.
// The receiver cannot stall; done is high for one cycle with each result, which holds on the ports until the next.
// Reset clears both stack heights and the controller; store contents are not cleared.
module dual_stack_shared_memory_top #(
	parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic signed [31:0] push_value,
	output logic done,
	output logic signed [31:0] pop_value,
	output logic [1:0] status
);

	dssm_pkg::cmd_t cmd;
	dssm_pkg::stat_t stat;

	dssm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.stat(stat),
		.cmd(cmd)
	);

	dssm_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.operation(operation),
		.push_value(push_value),
		.done(done),
		.pop_value(pop_value),
		.status(status)
	);

endmodule
